FILE: hw/rtl/wmm_pkg.sv
// Shared types and constants for the waveform min/max/rms overview builder.
// No dependencies.
`default_nettype none

package wmm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RMS_W    = 16;
  localparam int LEVEL_W  = 3;

  localparam logic signed [SAMPLE_W-1:0] POS_FULL = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] NEG_FULL = 16'sh8000;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_LEVEL_COUNT   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         level;
    logic signed [SAMPLE_W-1:0] bmin;
    logic signed [SAMPLE_W-1:0] bmax;
    logic [RMS_W-1:0]           rms;
    logic                       last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wmm_fifo.sv
// Small register FIFO, used for the command queue and the result queue.
// No package dependencies. DEPTH must be a power of two.
`default_nettype none

module wmm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        mem[wr_ptr] <= wdata;
        wr_ptr      <= wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wmm_front.sv
// Front end: accepts frames and flushes, keeps the base bucket accumulators
// and issues bucket-close / flush requests. Depends on wmm_pkg.
`default_nettype none

module wmm_front
  import wmm_pkg::*;
#(
  parameter int FPB          = 16,
  parameter int MAX_CHANNELS = 2,
  parameter int SUM_W        = 36,
  parameter int CNT_W        = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       opcode,
  input  wire logic signed [SAMPLE_W-1:0] sample_a,
  input  wire logic signed [SAMPLE_W-1:0] sample_b,
  input  wire logic [1:0]                 chans,
  output logic                            cmd_push,
  input  wire logic                       cmd_full,
  output logic                            cmd_flush,
  output logic                            cmd_has_base,
  output logic signed [SAMPLE_W-1:0]      cmd_min,
  output logic signed [SAMPLE_W-1:0]      cmd_max,
  output logic [SUM_W-1:0]                cmd_sum,
  output logic [CNT_W-1:0]                cmd_count
);

  typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_ACCUM, F_ISSUE} fstate_t;

  fstate_t                    state;
  logic                       op_flush;
  logic signed [SAMPLE_W-1:0] a;
  logic signed [SAMPLE_W-1:0] b;
  logic [30:0]                sq_a;
  logic [30:0]                sq_b;
  logic signed [SAMPLE_W-1:0] base_min;
  logic signed [SAMPLE_W-1:0] base_max;
  logic [SUM_W-1:0]           base_sum;
  logic [CNT_W-1:0]           base_count;

  logic signed [31:0]         prod_a;
  logic signed [31:0]         prod_b;
  logic                       two_ch;
  logic [31:0]                frame_sq;
  logic signed [SAMPLE_W-1:0] min_a;
  logic signed [SAMPLE_W-1:0] max_a;
  logic signed [SAMPLE_W-1:0] min_next;
  logic signed [SAMPLE_W-1:0] max_next;
  logic [CNT_W-1:0]           count_inc;

  always_comb begin
    prod_a = a * a;
    prod_b = b * b;
    two_ch = (chans == 2'd2);
    // one-channel frames are weighted up so the divisor stays frames*MAX_CHANNELS
    if (two_ch) begin
      frame_sq = {1'b0, sq_a} + {1'b0, sq_b};
    end else if (MAX_CHANNELS == 2) begin
      frame_sq = {sq_a, 1'b0};
    end else begin
      frame_sq = {1'b0, sq_a};
    end
    min_a    = (a < base_min) ? a : base_min;
    max_a    = (a > base_max) ? a : base_max;
    min_next = (two_ch && (b < min_a)) ? b : min_a;
    max_next = (two_ch && (b > max_a)) ? b : max_a;
    count_inc = base_count + 1'b1;
  end

  assign full         = (state != F_IDLE);
  assign cmd_push     = (state == F_ISSUE) && !cmd_full;
  assign cmd_flush    = op_flush;
  assign cmd_has_base = (base_count != '0);
  assign cmd_min      = (op_flush && (base_min == POS_FULL)) ? '0 : base_min;
  assign cmd_max      = (op_flush && (base_max == NEG_FULL)) ? '0 : base_max;
  assign cmd_sum      = base_sum;
  assign cmd_count    = base_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      op_flush   <= 1'b0;
      base_min   <= POS_FULL;
      base_max   <= NEG_FULL;
      base_sum   <= '0;
      base_count <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            op_flush <= (opcode == OP_FLUSH);
            a        <= sample_a;
            b        <= sample_b;
            state    <= (opcode == OP_FLUSH) ? F_ISSUE : F_SQUARE;
          end
        end
        F_SQUARE: begin
          sq_a  <= prod_a[30:0];
          sq_b  <= prod_b[30:0];
          state <= F_ACCUM;
        end
        F_ACCUM: begin
          base_min   <= min_next;
          base_max   <= max_next;
          base_sum   <= base_sum + SUM_W'(frame_sq);
          base_count <= count_inc;
          state      <= (count_inc >= CNT_W'(FPB)) ? F_ISSUE : F_IDLE;
        end
        F_ISSUE: begin
          if (!cmd_full) begin
            base_min   <= POS_FULL;
            base_max   <= NEG_FULL;
            base_sum   <= '0;
            base_count <= '0;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wmm_mean_root.sv
// Iterative mean and root unit: restoring divide one bit a cycle, then
// integer square root two bits a cycle. No package dependencies.
`default_nettype none

module wmm_mean_root #(
  parameter int DIV_W = 36,
  parameter int DVS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [15:0]           root
);

  localparam int CW = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

  rstate_t          state;
  logic [DIV_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [31:0]      val;
  logic [31:0]      res;
  logic [31:0]      bitm;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [31:0]      trial;

  always_comb begin
    rem_sh = {rem, dvd[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs});
    trial  = res + bitm;
  end

  assign root = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            dvd   <= dividend;
            dvs   <= divisor;
            rem   <= '0;
            cnt   <= CW'(DIV_W);
            state <= R_DIV;
          end
        end
        R_DIV: begin
          if (cnt != '0) begin
            rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
            dvd <= {dvd[DIV_W-2:0], ge};
            cnt <= cnt - 1'b1;
          end else begin
            // mean square never exceeds 2^30, low 32 bits hold it
            val   <= dvd[31:0];
            res   <= '0;
            bitm  <= 32'h4000_0000;
            state <= R_SQRT;
          end
        end
        R_SQRT: begin
          if (val >= trial) begin
            val <= val - trial;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm == 32'd1) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wmm_back.sv
// Back end: turns close/flush requests into base and coarse buckets, keeps
// the coarse level accumulators. Depends on wmm_pkg and wmm_mean_root.
`default_nettype none

module wmm_back
  import wmm_pkg::*;
#(
  parameter int FPB          = 16,
  parameter int MERGE_FACTOR = 4,
  parameter int MAX_LEVELS   = 6,
  parameter int MAX_CHANNELS = 2,
  parameter int SUM_W        = 36,
  parameter int CNT_W        = 5,
  parameter int LV_W         = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [LV_W-1:0]            levels,
  input  wire logic                       cmd_empty,
  output logic                            cmd_pop,
  input  wire logic                       cmd_flush,
  input  wire logic                       cmd_has_base,
  input  wire logic signed [SAMPLE_W-1:0] cmd_min,
  input  wire logic signed [SAMPLE_W-1:0] cmd_max,
  input  wire logic [SUM_W-1:0]           cmd_sum,
  input  wire logic [CNT_W-1:0]           cmd_count,
  output logic                            res_push,
  input  wire logic                       res_full,
  output result_t                         res
);

  localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CCNT_W = $clog2(MERGE_FACTOR + 1);
  localparam int CSUM_W = 31 + $clog2(MERGE_FACTOR);
  localparam int DIV_W  = (SUM_W > CSUM_W) ? SUM_W : CSUM_W;
  localparam int BDV_W  = $clog2(FPB * MAX_CHANNELS + 1);
  localparam int DVS_W  = (BDV_W > CCNT_W) ? BDV_W : CCNT_W;

  typedef enum logic [2:0] {
    B_IDLE, B_BASE_WAIT, B_EMIT, B_STEP, B_CHECK, B_COARSE_WAIT
  } bstate_t;

  bstate_t                    state;
  logic                       flush;
  logic                       have;
  logic [LV_W-1:0]            lvl;
  logic signed [SAMPLE_W-1:0] cur_min;
  logic signed [SAMPLE_W-1:0] cur_max;
  logic [RMS_W-1:0]           cur_rms;
  logic [31:0]                rms_sq;
  logic                       root_start;
  logic [DIV_W-1:0]           root_dvd;
  logic [DVS_W-1:0]           root_dvs;
  logic                       root_done;
  logic [15:0]                root_value;

  logic signed [SAMPLE_W-1:0] cmin [MAX_LEVELS];
  logic signed [SAMPLE_W-1:0] cmax [MAX_LEVELS];
  logic [CSUM_W-1:0]          csum [MAX_LEVELS];
  logic [CCNT_W-1:0]          ccnt [MAX_LEVELS];

  logic [LV_W-1:0]  nxt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] nidx;
  logic [31:0]      rms_prod;
  logic             crossed;
  logic             emit_last;

  always_comb begin
    nxt      = lvl + 1'b1;
    idx      = lvl[IDX_W-1:0];
    nidx     = (nxt < LV_W'(MAX_LEVELS)) ? nxt[IDX_W-1:0] : '0;
    rms_prod = cur_rms * cur_rms;
    crossed  = (cmax[idx] < cmin[idx]);
    // a flush always carries the chain upward; a close stops at a level not yet full
    emit_last = (nxt >= levels) ||
                (!flush && (({1'b0, ccnt[nidx]} + 1'b1) < (CCNT_W+1)'(MERGE_FACTOR)));
  end

  assign cmd_pop   = (state == B_IDLE) && !cmd_empty;
  assign res_push  = (state == B_EMIT) && !res_full;
  assign res.level = LEVEL_W'(lvl);
  assign res.bmin  = cur_min;
  assign res.bmax  = cur_max;
  assign res.rms   = cur_rms;
  assign res.last  = emit_last;

  wmm_mean_root #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .dividend (root_dvd),
    .divisor  (root_dvs),
    .done     (root_done),
    .root     (root_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      root_start <= 1'b0;
      flush      <= 1'b0;
      have       <= 1'b0;
      lvl        <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        cmin[i] <= POS_FULL;
        cmax[i] <= NEG_FULL;
        csum[i] <= '0;
        ccnt[i] <= '0;
      end
    end else begin
      root_start <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!cmd_empty) begin
            flush   <= cmd_flush;
            cur_min <= cmd_min;
            cur_max <= cmd_max;
            if (cmd_has_base) begin
              lvl        <= '0;
              root_dvd   <= DIV_W'(cmd_sum);
              root_dvs   <= DVS_W'(cmd_count * MAX_CHANNELS);
              root_start <= 1'b1;
              state      <= B_BASE_WAIT;
            end else begin
              lvl   <= LV_W'(1);
              have  <= 1'b0;
              state <= B_STEP;
            end
          end
        end
        B_BASE_WAIT: begin
          if (root_done) begin
            cur_rms <= root_value;
            state   <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!res_full) begin
            rms_sq <= rms_prod;
            lvl    <= nxt;
            have   <= 1'b1;
            state  <= B_STEP;
          end
        end
        B_STEP: begin
          if (lvl >= levels) begin
            if (flush) begin
              for (int i = 0; i < MAX_LEVELS; i++) begin
                cmin[i] <= POS_FULL;
                cmax[i] <= NEG_FULL;
                csum[i] <= '0;
                ccnt[i] <= '0;
              end
            end
            state <= B_IDLE;
          end else begin
            if (have) begin
              if (cur_min < cmin[idx]) cmin[idx] <= cur_min;
              if (cur_max > cmax[idx]) cmax[idx] <= cur_max;
              csum[idx] <= csum[idx] + CSUM_W'(rms_sq);
              ccnt[idx] <= ccnt[idx] + 1'b1;
            end
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          if ((flush && (ccnt[idx] != '0)) ||
              (!flush && (ccnt[idx] >= CCNT_W'(MERGE_FACTOR)))) begin
            cur_min    <= crossed ? '0 : cmin[idx];
            cur_max    <= crossed ? '0 : cmax[idx];
            root_dvd   <= DIV_W'(csum[idx]);
            root_dvs   <= DVS_W'(ccnt[idx]);
            root_start <= 1'b1;
            state      <= B_COARSE_WAIT;
          end else if (flush) begin
            have  <= 1'b0;
            lvl   <= nxt;
            state <= B_STEP;
          end else begin
            state <= B_IDLE;
          end
        end
        B_COARSE_WAIT: begin
          if (root_done) begin
            cur_rms   <= root_value;
            cmin[idx] <= POS_FULL;
            cmax[idx] <= NEG_FULL;
            csum[idx] <= '0;
            ccnt[idx] <= '0;
            state     <= B_EMIT;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/waveform_minmax_rms_mip_builder.sv
// Top level of the waveform min/max/rms overview builder.
// Depends on wmm_pkg, wmm_fifo, wmm_front, wmm_back (and wmm_mean_root).
//
// Usage:
//  - Input queue: drive opcode/sample_a/sample_b and raise push; the item is
//    taken on an edge with push high and full low. opcode push adds one
//    frame, opcode flush emits every partial bucket and clears all levels.
//  - Result queue: while empty is low, the oldest bucket sits on level,
//    bucket_min, bucket_max, bucket_rms, last; pop takes it. last marks the
//    final bucket caused by one input item.
//  - APB port: channel_count at 0x0, level_count at 0x4; pready is tied high.
//    Write only while the block is idle.
// Operation:
//  - The front end takes a frame through accept, square and accumulate steps;
//    a frame that closes a base bucket adds an issue step, and a flush goes
//    through accept and issue. full stays high in between.
//  - Each emitted bucket passes through the shared divide/square-root unit, so
//    a full cascade of 6 levels runs its buckets through that unit one after
//    another; the command queue lets the front keep taking frames.
//  - A stalled result queue (pop low) fills the 8-entry result queue, then
//    backs up the back end, the 2-entry command queue and finally full.
// Reset: synchronous, active high; clears all accumulators, both queues and
//  restores channel_count=2, level_count=6. No clearing pass is needed.
`default_nettype none

module waveform_minmax_rms_mip_builder
  import wmm_pkg::*;
#(
  parameter int FRAMES_PER_BUCKET = 16,
  parameter int MERGE_FACTOR      = 4,
  parameter int MAX_LEVELS        = 6,
  parameter int MAX_CHANNELS      = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // requests in
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       opcode,
  input  wire logic signed [SAMPLE_W-1:0] sample_a,
  input  wire logic signed [SAMPLE_W-1:0] sample_b,
  // buckets out
  output logic                            empty,
  input  wire logic                       pop,
  output logic [LEVEL_W-1:0]              level,
  output logic signed [SAMPLE_W-1:0]      bucket_min,
  output logic signed [SAMPLE_W-1:0]      bucket_max,
  output logic [RMS_W-1:0]                bucket_rms,
  output logic                            last
);

  // base sum: per frame at most 2^31, times the frame count
  localparam int SUM_W    = 32 + $clog2(FRAMES_PER_BUCKET);
  localparam int CNT_W    = $clog2(FRAMES_PER_BUCKET + 1);
  localparam int LV_W     = $clog2(MAX_LEVELS + 1);
  localparam int CMD_W    = 2 + 2 * SAMPLE_W + SUM_W + CNT_W;
  localparam int RES_W    = $bits(result_t);
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 8;

  // config registers
  logic [1:0] channel_count;
  logic [2:0] level_count;
  logic [1:0] chans_eff;
  logic [LV_W-1:0] levels_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd2;
      level_count   <= 3'd6;
    end else if (psel && penable && pwrite) begin
      case (reg_index_t'(paddr[2]))
        REG_CHANNEL_COUNT: channel_count <= pwdata[1:0];
        REG_LEVEL_COUNT:   level_count   <= pwdata[2:0];
        default:           channel_count <= channel_count;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      REG_LEVEL_COUNT:   prdata = 32'(level_count);
      default:           prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // out-of-range settings clamp to the nearest legal value
  always_comb begin
    if (channel_count == 2'd0) begin
      chans_eff = 2'd1;
    end else if (channel_count > 2'(MAX_CHANNELS)) begin
      chans_eff = 2'(MAX_CHANNELS);
    end else begin
      chans_eff = channel_count;
    end
    if (level_count == 3'd0) begin
      levels_eff = LV_W'(1);
    end else if (32'(level_count) > MAX_LEVELS) begin
      levels_eff = LV_W'(MAX_LEVELS);
    end else begin
      levels_eff = LV_W'(level_count);
    end
  end

  // front end -> command queue
  logic                       cmd_push;
  logic                       cmd_full;
  logic                       cmd_pop;
  logic                       cmd_empty;
  logic                       f_flush;
  logic                       f_has_base;
  logic signed [SAMPLE_W-1:0] f_min;
  logic signed [SAMPLE_W-1:0] f_max;
  logic [SUM_W-1:0]           f_sum;
  logic [CNT_W-1:0]           f_count;
  logic [CMD_W-1:0]           cmd_wdata;
  logic [CMD_W-1:0]           cmd_rdata;
  logic                       b_flush;
  logic                       b_has_base;
  logic signed [SAMPLE_W-1:0] b_min;
  logic signed [SAMPLE_W-1:0] b_max;
  logic [SUM_W-1:0]           b_sum;
  logic [CNT_W-1:0]           b_count;

  wmm_front #(
    .FPB          (FRAMES_PER_BUCKET),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .chans        (chans_eff),
    .cmd_push     (cmd_push),
    .cmd_full     (cmd_full),
    .cmd_flush    (f_flush),
    .cmd_has_base (f_has_base),
    .cmd_min      (f_min),
    .cmd_max      (f_max),
    .cmd_sum      (f_sum),
    .cmd_count    (f_count)
  );

  assign cmd_wdata = {f_flush, f_has_base, f_min, f_max, f_sum, f_count};
  assign {b_flush, b_has_base, b_min, b_max, b_sum, b_count} = cmd_rdata;

  wmm_fifo #(
    .W     (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // back end -> result queue
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  wmm_back #(
    .FPB          (FRAMES_PER_BUCKET),
    .MERGE_FACTOR (MERGE_FACTOR),
    .MAX_LEVELS   (MAX_LEVELS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W),
    .LV_W         (LV_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .levels       (levels_eff),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd_flush    (b_flush),
    .cmd_has_base (b_has_base),
    .cmd_min      (b_min),
    .cmd_max      (b_max),
    .cmd_sum      (b_sum),
    .cmd_count    (b_count),
    .res_push     (res_push),
    .res_full     (res_full),
    .res          (res_in)
  );

  wmm_fifo #(
    .W     (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign level      = res_out.level;
  assign bucket_min = res_out.bmin;
  assign bucket_max = res_out.bmax;
  assign bucket_rms = res_out.rms;
  assign last       = res_out.last;

  // checks
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full) else $error("command queue overflow");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result queue overflow");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (32'(level) < 32'(levels_eff))) else $error("bucket level out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty) else $error("result queue not empty after reset");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for waveform_minmax_rms_mip_builder: directed and random requests,
// checked against a predictor of min/max/rms buckets. Depends on wmm_pkg and the RTL.
`default_nettype none

module tb;
  import wmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = 16;
  localparam int MERGE = 4;
  localparam int LEVELS = 6;
  localparam int CHANS = 2;
  localparam int LIMIT = 2000000;
  // worst cascade through the shared divide/root unit, plus margin
  localparam int DRAIN_CYCLES = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic opcode = OP_PUSH;
  logic signed [15:0] sample_a = '0, sample_b = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] level;
  logic signed [15:0] bucket_min, bucket_max;
  logic [15:0] bucket_rms;
  logic last;

  always #5 clk = ~clk;

  waveform_minmax_rms_mip_builder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .opcode(opcode),
    .sample_a(sample_a), .sample_b(sample_b),
    .empty(empty), .pop(pop), .level(level), .bucket_min(bucket_min),
    .bucket_max(bucket_max), .bucket_rms(bucket_rms), .last(last)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's accumulators and registers.
  // ---------------------------------------------------------------------------
  logic [1:0] chan_reg;
  logic [2:0] lvl_reg;
  int base_lo, base_hi;
  longint unsigned base_sq;
  int base_frames;
  int crs_lo[LEVELS];
  int crs_hi[LEVELS];
  longint unsigned crs_sq[LEVELS];
  int crs_kids[LEVELS];

  result_t bucket_q[$];   // expected buckets, oldest first
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;       // long receiver stall, counted in the pop process
  bit stall_rx = 1'b1;    // random pop stalls enabled

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_base_acc();
    base_lo = 32767;
    base_hi = -32768;
    base_sq = 0;
    base_frames = 0;
  endfunction

  function automatic void clear_crs(int l);
    crs_lo[l] = 32767;
    crs_hi[l] = -32768;
    crs_sq[l] = 0;
    crs_kids[l] = 0;
  endfunction

  function automatic void clear_all();
    clear_base_acc();
    for (int l = 0; l < LEVELS; l++) clear_crs(l);
  endfunction

  function automatic void add_bucket(int l, int mn, int mx, longint unsigned r);
    result_t b;
    b.level = l[2:0];
    b.bmin = mn[15:0];
    b.bmax = mx[15:0];
    b.rms = r[15:0];
    b.last = 1'b0;
    bucket_q = {bucket_q, b};
  endfunction

  function automatic void merge_into(int l, int mn, int mx, longint unsigned r);
    if (mn < crs_lo[l]) crs_lo[l] = mn;
    if (mx > crs_hi[l]) crs_hi[l] = mx;
    crs_sq[l] += r * r;
    crs_kids[l]++;
  endfunction

  // close a coarse level; crossed bounds report as zero
  function automatic void close_crs(int l, output int mn, output int mx,
                                    output longint unsigned r);
    mn = crs_lo[l];
    mx = crs_hi[l];
    if (mx < mn) begin
      mn = 0;
      mx = 0;
    end
    r = int_sqrt(crs_sq[l] / crs_kids[l]);
    add_bucket(l, mn, mx, r);
    clear_crs(l);
  endfunction

  function automatic void predict_buckets(logic op, logic signed [15:0] a,
                                          logic signed [15:0] b);
    int nlev, ch, mn, mx, n_before;
    longint unsigned r, sq;
    bit have;
    nlev = (lvl_reg == 0) ? 1 : (lvl_reg > LEVELS) ? LEVELS : lvl_reg;
    ch = (chan_reg == 0) ? 1 : (chan_reg > CHANS) ? CHANS : chan_reg;
    n_before = bucket_q.size();
    if (op == OP_PUSH) begin
      sq = longint'(a) * longint'(a);
      if (a < base_lo) base_lo = a;
      if (a > base_hi) base_hi = a;
      if (ch == 2) begin
        if (b < base_lo) base_lo = b;
        if (b > base_hi) base_hi = b;
        sq += longint'(b) * longint'(b);
      end
      base_sq += sq * (CHANS / ch);
      base_frames++;
      if (base_frames >= FRAMES) begin
        mn = base_lo;
        mx = base_hi;
        r = int_sqrt(base_sq / (base_frames * CHANS));
        add_bucket(0, mn, mx, r);
        clear_base_acc();
        for (int l = 1; l < nlev; l++) begin
          merge_into(l, mn, mx, r);
          if (crs_kids[l] < MERGE) break;
          close_crs(l, mn, mx, r);
        end
      end
    end else begin
      have = 1'b0;
      mn = 0;
      mx = 0;
      r = 0;
      if (base_frames > 0) begin
        // untouched base sentinels report as zero
        mn = (base_lo == 32767) ? 0 : base_lo;
        mx = (base_hi == -32768) ? 0 : base_hi;
        r = int_sqrt(base_sq / (base_frames * CHANS));
        add_bucket(0, mn, mx, r);
        have = 1'b1;
      end
      for (int l = 1; l < nlev; l++) begin
        if (have) merge_into(l, mn, mx, r);
        have = 1'b0;
        if (crs_kids[l] > 0) begin
          close_crs(l, mn, mx, r);
          have = 1'b1;
        end
      end
      clear_all();
    end
    if (bucket_q.size() > n_before) bucket_q[bucket_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver; sender bursts and gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(logic op, logic signed [15:0] a, logic signed [15:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    push <= 1'b1;
    opcode <= op;
    sample_a <= a;
    sample_b <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_buckets(op, a, b);
    // push stays high here; the next call or idle_push decides what follows
  endtask

  task automatic idle_push();
    push <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    idle_push();
    @(posedge clk);
    while (bucket_q.size() != 0) @(posedge clk);
    // a frame that closes no bucket may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_CHANNEL_COUNT) chan_reg = val[1:0];
    else lvl_reg = val[2:0];
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ch, logic [31:0] lv);
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, ch);
    write_reg(REG_LEVEL_COUNT, lv);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_extremes();
    // full-scale values both ways, then a flush of a partial bucket
    for (int i = 0; i < 16; i++)
      send_request(OP_PUSH, (i % 2) ? 16'sh7FFF : 16'sh8000,
                   (i % 3) ? 16'sh8000 : 16'sh7FFF);
    send_request(OP_PUSH, 16'sh0001, 16'shFFFF);
    send_request(OP_FLUSH, 16'sh0000, 16'sh0000);
    // flush with nothing pending gives no bucket
    send_request(OP_FLUSH, 16'sh1234, 16'sh4321);
  endtask

  task automatic test_flush_sentinels();
    // one channel, samples at full scale keep the base sentinels on flush
    configure(1, 6);
    send_request(OP_PUSH, 16'sh7FFF, 16'sh0000);
    send_request(OP_FLUSH, 16'sh0000, 16'sh0000);
    send_request(OP_PUSH, 16'sh8000, 16'sh5555);
    send_request(OP_FLUSH, 16'shAAAA, 16'sh5555);
  endtask

  task automatic test_out_of_range_regs();
    configure(0, 0);
    repeat (20) send_request(OP_PUSH, rand_sample(), rand_sample());
    send_request(OP_FLUSH, 16'sh0000, 16'sh0000);
    configure(3, 7);
    repeat (40) send_request(OP_PUSH, rand_sample(), rand_sample());
    send_request(OP_FLUSH, 16'sh0000, 16'sh0000);
  endtask

  // random pushes, with an occasional flush mid-way
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_request(OP_FLUSH, rand_sample(), rand_sample());
      else
        send_request(OP_PUSH, rand_sample(), rand_sample());
    end
  endtask

  task automatic test_backpressure();
    // receiver stalls long while requests keep coming; frequent flushes
    // produce enough buckets to fill the result queue, so full rises
    hold_off = 3000;
    for (int i = 0; i < 80; i++) begin
      if (i % 4 == 3)
        send_request(OP_FLUSH, rand_sample(), rand_sample());
      else
        send_request(OP_PUSH, rand_sample(), rand_sample());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop pattern and checking.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else if (stall_rx) begin
      pop <= (cycles % 97 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t exp_b;
    cycles++;
    if (!rst && pop && !empty) begin
      if (bucket_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bucket: level %0d min %0d max %0d rms %0d last %0b",
                   level, bucket_min, bucket_max, bucket_rms, last);
      end else begin
        exp_b = bucket_q.pop_front();
        if (exp_b.level !== level || exp_b.bmin !== bucket_min ||
            exp_b.bmax !== bucket_max || exp_b.rms !== bucket_rms ||
            exp_b.last !== last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("bucket mismatch: exp l%0d %0d/%0d rms %0d last %0b, got l%0d %0d/%0d rms %0d last %0b",
                     exp_b.level, exp_b.bmin, exp_b.bmax, exp_b.rms, exp_b.last,
                     level, bucket_min, bucket_max, bucket_rms, last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    chan_reg = 2'd2;
    lvl_reg = 3'd6;
    clear_all();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_flush_sentinels();
    test_out_of_range_regs();
    configure(2, 6);
    test_random(60);
    configure(1, 1);
    test_random(30);
    configure(2, 3);
    test_backpressure();
    configure(2, 6);
    stall_rx = 1'b0;
    test_random(40);
    send_request(OP_FLUSH, 16'sh0000, 16'sh0000);
    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/wmm_pkg.sv
hw/rtl/wmm_fifo.sv
hw/rtl/wmm_front.sv
hw/rtl/wmm_mean_root.sv
hw/rtl/wmm_back.sv
hw/rtl/waveform_minmax_rms_mip_builder.sv
bench/tb.sv
